// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ECU_ASSERT_IMP(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ecu: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define ECU_ASSERT_NEXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ecu: next-cycle check failed");

`endif

// ===== design/ecu_pkg.sv =====
package ecu_pkg;

	// Fixed-point formats
	localparam int FRAC_BITS  = 16;
	localparam int T_W        = FRAC_BITS + 1;
	localparam int OUT_W      = FRAC_BITS + 2;
	localparam int X_W        = T_W + 3;
	localparam int MODE_W     = 4;
	localparam int IN_DATA_W  = ((T_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((OUT_W + 7) / 8) * 8;

	// Pipeline depth, input register through output register
	localparam int NSTG = 6;

	// Elastic tables
	localparam int TAB_AW        = 8;
	localparam int TABLE_ENTRIES = 1 << TAB_AW;
	localparam int IP_W          = 4;
	localparam int SIN_W         = 32;
	localparam int EXP_W         = 31;
	localparam int PH_W          = 32;
	localparam int PH_SH         = PH_W - FRAC_BITS;

	localparam logic [T_W-1:0] ONE_FX  = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [T_W-1:0] HALF_FX = {2'b01, {(FRAC_BITS - 1){1'b0}}};

	localparam logic [63:0] Q30     = 64'd1 << 30;
	localparam logic [63:0] PI_Q30  = 64'd3373259426;
	localparam logic [63:0] LN2_Q30 = 64'd744261118;
	localparam logic [63:0] C1_Q30  = 64'd1827057613;

	// Back-out overshoot constants in Q.FRAC_BITS
	localparam logic [T_W-1:0] BACK_C1 =
		T_W'((C1_Q30 + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
	localparam logic [T_W:0] BACK_C3 = {1'b0, BACK_C1} + {1'b0, ONE_FX};

	// Reciprocal of three, exact for any x below 2^(DIV3_SH-1)
	localparam int DIV3_SH = X_W + 2;
	localparam logic [X_W:0] DIV3_M = (X_W + 1)'(((64'd1 << DIV3_SH) + 64'd2) / 3);
	localparam logic [PH_SH-1:0] THIRD_STEP = PH_SH'((64'd1 << PH_SH) / 3);
	localparam logic [PH_W-1:0] PH_BIAS = PH_W'(64'd3 << 30);

	// Mode codes on the request tuser
	localparam logic [MODE_W-1:0] MODE_LINEAR    = 4'd0;
	localparam logic [MODE_W-1:0] MODE_QIN       = 4'd1;
	localparam logic [MODE_W-1:0] MODE_QOUT      = 4'd2;
	localparam logic [MODE_W-1:0] MODE_QIO       = 4'd3;
	localparam logic [MODE_W-1:0] MODE_QIN_ALT   = 4'd4;
	localparam logic [MODE_W-1:0] MODE_QOUT_ALT  = 4'd5;
	localparam logic [MODE_W-1:0] MODE_QIO_ALT   = 4'd6;
	localparam logic [MODE_W-1:0] MODE_CIN       = 4'd7;
	localparam logic [MODE_W-1:0] MODE_COUT      = 4'd8;
	localparam logic [MODE_W-1:0] MODE_CIO       = 4'd9;
	localparam logic [MODE_W-1:0] MODE_BACK      = 4'd10;
	localparam logic [MODE_W-1:0] MODE_ELASTIC   = 4'd11;

	typedef enum logic [3:0] {
		CRV_LINEAR,
		CRV_QUAD_IN,
		CRV_QUAD_OUT,
		CRV_QUAD_IO,
		CRV_CUBIC_IN,
		CRV_CUBIC_OUT,
		CRV_CUBIC_IO,
		CRV_BACK_OUT,
		CRV_ELASTIC
	} curve_t;

	typedef struct packed {
		curve_t         curve;
		logic           lo;
		logic [T_W-1:0] opa;
		logic [T_W-1:0] opb;
		logic [T_W-1:0] opc;
	} poly_in_t;

	typedef struct packed {
		logic [X_W-1:0] x;
		logic           at_zero;
		logic           at_one;
	} el_in_t;

	typedef logic signed [SIN_W-1:0] sin_tab_t [TABLE_ENTRIES];
	typedef logic [EXP_W-1:0] exp_tab_t [TABLE_ENTRIES];

	// First-quadrant sine by Taylor series, r in quarter turns (Q30), result Q30
	function automatic logic [63:0] sin_quadrant(input logic [63:0] r);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] pos;
		logic [63:0] neg;
		x = (r * PI_Q30) >> 31;
		x2 = (x * x) >> 30;
		term = x;
		pos = x;
		neg = 64'd0;
		for (int n = 1; n <= 7; n++) begin
			term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
			if ((n & 1) != 0) begin
				neg = neg + term;
			end else begin
				pos = pos + term;
			end
		end
		if (neg >= pos) begin
			return 64'd0;
		end
		pos = pos - neg;
		return (pos > Q30) ? Q30 : pos;
	endfunction

	function automatic sin_tab_t build_sin_tab();
		sin_tab_t tab;
		logic [63:0] a;
		logic [63:0] q;
		logic [63:0] r;
		logic [63:0] s;
		for (int k = 0; k < TABLE_ENTRIES; k++) begin
			a = 64'(k) << (32 - TAB_AW);
			q = (a >> 30) & 64'd3;
			r = a & (Q30 - 64'd1);
			s = q[0] ? sin_quadrant(Q30 - r) : sin_quadrant(r);
			tab[k] = (q >= 64'd2) ? SIN_W'(64'd0 - s) : SIN_W'(s);
		end
		return tab;
	endfunction

	// Unsigned quotient by shift and subtract, one bit per step
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] quo;
		logic [64:0] part;
		quo = 64'd0;
		part = 65'd0;
		for (int b = 63; b >= 0; b--) begin
			part = {part[63:0], num[b]};
			if (part >= {1'b0, den}) begin
				part = part - {1'b0, den};
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// 2^(-k/N) in Q30 as the inverse of a Taylor series of exp(k*ln2/N)
	function automatic exp_tab_t build_exp_tab();
		exp_tab_t tab;
		logic [63:0] y;
		logic [63:0] term;
		logic [63:0] sum;
		for (int k = 0; k < TABLE_ENTRIES; k++) begin
			y = (LN2_Q30 * 64'(k)) >> TAB_AW;
			term = Q30;
			sum = Q30;
			for (int n = 1; n <= 12; n++) begin
				term = ((term * y) >> 30) / 64'(n);
				sum = sum + term;
			end
			tab[k] = EXP_W'(udiv64((64'd1 << 60) + (sum >> 1), sum));
		end
		return tab;
	endfunction

	localparam sin_tab_t SIN_TAB = build_sin_tab();
	localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

// ===== design/ecu_ctrl.sv =====
`include "assert_macros.svh"

module ecu_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [ecu_pkg::NSTG-1:0]  en
);
	import ecu_pkg::*;

	logic [NSTG-1:0] vld_q;
	logic            in_acc;
	logic            out_acc;

	// A stage loads when it is empty or its successor moves on
	always_comb begin
		en[NSTG-1] = !vld_q[NSTG-1] || m_tready;
		for (int k = NSTG - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k + 1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= (vld_q & ~en) | ({vld_q[NSTG-2:0], s_tvalid} & en);
		end
	end

	assign s_tready = en[0];
	assign m_tvalid = vld_q[NSTG-1];
	assign in_acc   = s_tvalid && s_tready;
	assign out_acc  = m_tvalid && m_tready;

	`ECU_ASSERT_IMP(a_bubble_ready, clk, arst_n, vld_q != '1, s_tready)
	`ECU_ASSERT_IMP(a_en_order, clk, arst_n, 1'b1, ((en >> 1) & ~en) == '0)
	`ECU_ASSERT_NEXT(a_count_kept, clk, arst_n, 1'b1, $countones(vld_q) == $past($countones(vld_q)) + int'($past(in_acc)) - int'($past(out_acc)))

endmodule

// ===== design/ecu_poly.sv =====
module ecu_poly (
	input  logic                           clk,
	input  logic [ecu_pkg::NSTG-1:0]       en,
	input  ecu_pkg::poly_in_t              in_s1,
	output logic [ecu_pkg::OUT_W-1:0]      res_s5
);
	import ecu_pkg::*;

	localparam int P_W = 2 * T_W;
	localparam logic [P_W-1:0] P_HALF  = P_W'(1) << (FRAC_BITS - 1);
	localparam logic [P_W-1:0] P_ONE   = P_W'(1) << FRAC_BITS;
	localparam logic [P_W:0]   M3_HALF = (P_W + 1)'(1) << (FRAC_BITS - 1);

	curve_t         curve_s2, curve_s3, curve_s4;
	logic           lo_s2, lo_s3, lo_s4;
	logic [T_W-1:0] opc_s2;
	logic [P_W-1:0] p1_s2;
	logic [T_W-1:0] r1_s3, r1_s4;
	logic [P_W-1:0] p2_s3;
	logic [T_W-1:0] r2_s4;
	logic [P_W:0]   m3_s4;
	logic [P_W-1:0] m1_s4;

	logic [T_W-1:0] r1;
	logic [T_W-1:0] r2;
	logic [T_W:0]   fm3;
	logic [T_W-1:0] fm1;
	logic [T_W-1:0] half_r2;
	logic [OUT_W-1:0] one_w;
	logic [OUT_W-1:0] res;

	// First product
	always_ff @(posedge clk) begin
		if (en[1]) begin
			curve_s2 <= in_s1.curve;
			lo_s2    <= in_s1.lo;
			opc_s2   <= in_s1.opc;
			p1_s2    <= in_s1.opa * in_s1.opb;
		end
	end

	// Round the first product; the upper half of quad in-out rounds v*v/2
	always_comb begin
		if (curve_s2 == CRV_QUAD_IO && !lo_s2) begin
			r1 = T_W'((p1_s2 + P_ONE) >> (FRAC_BITS + 1));
		end else begin
			r1 = T_W'((p1_s2 + P_HALF) >> FRAC_BITS);
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			curve_s3 <= curve_s2;
			lo_s3    <= lo_s2;
			r1_s3    <= r1;
			p2_s3    <= r1 * opc_s2;
		end
	end

	assign r2 = T_W'((p2_s3 + P_HALF) >> FRAC_BITS);

	// Back-out terms: c3*u^3 and c1*u^2
	always_ff @(posedge clk) begin
		if (en[3]) begin
			curve_s4 <= curve_s3;
			lo_s4    <= lo_s3;
			r1_s4    <= r1_s3;
			r2_s4    <= r2;
			m3_s4    <= BACK_C3 * r2;
			m1_s4    <= BACK_C1 * r1_s3;
		end
	end

	// Combine in OUT_W bits; wraparound matches the output mask
	always_comb begin
		fm3     = (T_W + 1)'((m3_s4 + M3_HALF) >> FRAC_BITS);
		fm1     = T_W'((m1_s4 + P_HALF) >> FRAC_BITS);
		half_r2 = T_W'(({1'b0, r2_s4} + (T_W + 1)'(1)) >> 1);
		one_w   = OUT_W'(ONE_FX);
		case (curve_s4) inside
			CRV_QUAD_OUT:  res = one_w - OUT_W'(r1_s4);
			CRV_QUAD_IO:   res = lo_s4 ? OUT_W'(r1_s4) : one_w - OUT_W'(r1_s4);
			CRV_CUBIC_IN:  res = OUT_W'(r2_s4);
			CRV_CUBIC_OUT: res = one_w - OUT_W'(r2_s4);
			CRV_CUBIC_IO:  res = lo_s4 ? OUT_W'(r2_s4) : one_w - OUT_W'(half_r2);
			CRV_BACK_OUT:  res = one_w - OUT_W'(fm3) + OUT_W'(fm1);
			default:       res = OUT_W'(r1_s4);
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			res_s5 <= res;
		end
	end

endmodule

// ===== design/ecu_elastic.sv =====
module ecu_elastic (
	input  logic                        clk,
	input  logic [ecu_pkg::NSTG-1:0]    en,
	input  ecu_pkg::el_in_t             in_s1,
	output logic [ecu_pkg::OUT_W-1:0]   res
);
	import ecu_pkg::*;

	localparam int QP_W = 2 * X_W + 1;
	localparam int EI_SH = FRAC_BITS - TAB_AW;
	localparam logic [FRAC_BITS:0] EI_HALF = (FRAC_BITS + 1)'(1) << (EI_SH - 1);
	localparam int PR_W = 2 * EXP_W;
	localparam logic [PR_W-1:0] SC_HALF = PR_W'(1) << (59 - FRAC_BITS);

	logic [QP_W-1:0]   qp_s2;
	logic [X_W-1:0]    x_s2;
	logic [TAB_AW-1:0] ei_s2;
	logic [IP_W-1:0]   ip_s2;
	logic [TAB_AW-1:0] si_s3;
	logic [EXP_W-1:0]  e_s3, e_s4;
	logic [EXP_W-1:0]  mag_s4;
	logic              neg_s4, neg_s5;
	logic [PR_W-1:0]   p_s5;
	logic              zero_s2, zero_s3, zero_s4, zero_s5;
	logic              one_s2, one_s3, one_s4, one_s5;

	logic [TAB_AW:0]      ei_full;
	logic [IP_W-1:0]      ip;
	logic [PH_W-PH_SH-1:0] q_lo;
	logic [1:0]           rem;
	logic [PH_W-1:0]      ph;
	logic [TAB_AW-1:0]    si;
	logic signed [SIN_W-1:0] s;
	logic [T_W-1:0]       scaled;

	// Octave split of 10t; rounding up to a full octave bumps the shift
	always_comb begin
		ei_full = (TAB_AW + 1)'(({1'b0, in_s1.x[FRAC_BITS-1:0]} + EI_HALF) >> EI_SH);
		ip = in_s1.x[X_W-1:FRAC_BITS] + IP_W'(ei_full[TAB_AW]);
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			qp_s2   <= in_s1.x * DIV3_M;
			x_s2    <= in_s1.x;
			ei_s2   <= ei_full[TAB_AW-1:0];
			ip_s2   <= ip;
			zero_s2 <= in_s1.at_zero;
			one_s2  <= in_s1.at_one;
		end
	end

	// Phase = 10t/3 - 1/4 turn; only the low quotient bits and the remainder matter
	always_comb begin
		q_lo = qp_s2[DIV3_SH +: (PH_W - PH_SH)];
		rem  = x_s2[1:0] - q_lo[1:0] - {q_lo[0], 1'b0};
		ph   = {q_lo, {PH_SH{1'b0}}} + PH_BIAS + PH_W'(rem) * PH_W'(THIRD_STEP);
		si   = ph[PH_W-1 -: TAB_AW] + TAB_AW'(ph[PH_W-1-TAB_AW]);
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			si_s3   <= si;
			e_s3    <= EXP_TAB[ei_s2] >> ip_s2;
			zero_s3 <= zero_s2;
			one_s3  <= one_s2;
		end
	end

	assign s = SIN_TAB[si_s3];

	always_ff @(posedge clk) begin
		if (en[3]) begin
			neg_s4  <= s[SIN_W-1];
			mag_s4  <= s[SIN_W-1] ? EXP_W'(-s) : EXP_W'(s);
			e_s4    <= e_s3;
			zero_s4 <= zero_s3;
			one_s4  <= one_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			p_s5    <= e_s4 * mag_s4;
			neg_s5  <= neg_s4;
			zero_s5 <= zero_s4;
			one_s5  <= one_s4;
		end
	end

	// Round the Q60 product into Q.FRAC_BITS, then offset from 1.0
	always_comb begin
		scaled = T_W'((p_s5 + SC_HALF) >> (60 - FRAC_BITS));
		if (zero_s5) begin
			res = '0;
		end else if (one_s5) begin
			res = OUT_W'(ONE_FX);
		end else if (neg_s5) begin
			res = OUT_W'(ONE_FX) - OUT_W'(scaled);
		end else begin
			res = OUT_W'(ONE_FX) + OUT_W'(scaled);
		end
	end

endmodule

// ===== design/easing_curve_unit.sv =====
// Channel   | Dir | Handshake         | Payload
// ----------+-----+-------------------+------------------------------------------
// request   | in  | s_tvalid/s_tready | s_tdata: progress; s_tuser: mode
// result    | out | m_tvalid/m_tready | m_tdata: eased_value (signed Q2.16)
//
// One request per cycle, sustained while the result side keeps taking results; each request
// passes through the input register, four datapath stages (divide-by-three, table lookups
// and a 31x31 product set the depth) and the output register.
// Reset clears only the per-stage valid bits; payload registers start undefined.
// Each stage loads when it is empty or its successor moves, so a stalled
// output holds its result while bubbles behind it still close up.
module easing_curve_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [ecu_pkg::IN_DATA_W-1:0]    s_tdata,   // [16:0] progress
	input  logic [ecu_pkg::MODE_W-1:0]       s_tuser,   // [3:0] mode
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [ecu_pkg::OUT_DATA_W-1:0]   m_tdata    // [17:0] eased_value
);
	import ecu_pkg::*;

	logic [NSTG-1:0] en;

	logic [T_W-1:0] t;
	logic [T_W-1:0] u;
	logic [T_W-1:0] v;
	logic [T_W-1:0] t2;
	logic           lo;
	curve_t         curve;
	poly_in_t       poly_in;
	el_in_t         el_in;

	poly_in_t       poly_s1;
	el_in_t         el_s1;
	logic           is_el_s1, is_el_s2, is_el_s3, is_el_s4, is_el_s5;
	logic [OUT_W-1:0] poly_res_s5;
	logic [OUT_W-1:0] el_res;
	logic [OUT_W-1:0] res_s6;

	ecu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.en       (en)
	);

	// Saturate progress at 1.0; this clamps every curve at once
	always_comb begin
		t  = (s_tdata[T_W-1:0] > ONE_FX) ? ONE_FX : s_tdata[T_W-1:0];
		u  = ONE_FX - t;
		v  = {u[T_W-2:0], 1'b0};
		t2 = {t[T_W-2:0], 1'b0};
		lo = t < HALF_FX;

		// Fold duplicate codes; undefined codes fall back to linear
		unique case (s_tuser) inside
			MODE_QIN, MODE_QIN_ALT:   curve = CRV_QUAD_IN;
			MODE_QOUT, MODE_QOUT_ALT: curve = CRV_QUAD_OUT;
			MODE_QIO, MODE_QIO_ALT:   curve = CRV_QUAD_IO;
			MODE_CIN:                 curve = CRV_CUBIC_IN;
			MODE_COUT:                curve = CRV_CUBIC_OUT;
			MODE_CIO:                 curve = CRV_CUBIC_IO;
			MODE_BACK:                curve = CRV_BACK_OUT;
			MODE_ELASTIC:             curve = CRV_ELASTIC;
			default:                  curve = CRV_LINEAR;
		endcase

		// Pick multiplier operands: first product opa*opb, second times opc.
		// Linear multiplies by 1.0, which the rounding returns unchanged.
		poly_in.curve = curve;
		poly_in.lo    = lo;
		case (curve) inside
			CRV_QUAD_IN, CRV_CUBIC_IN: begin
				poly_in.opa = t;
				poly_in.opb = t;
				poly_in.opc = t;
			end
			CRV_QUAD_OUT, CRV_CUBIC_OUT, CRV_BACK_OUT: begin
				poly_in.opa = u;
				poly_in.opb = u;
				poly_in.opc = u;
			end
			CRV_QUAD_IO: begin
				poly_in.opa = lo ? t2 : v;
				poly_in.opb = lo ? t : v;
				poly_in.opc = v;
			end
			CRV_CUBIC_IO: begin
				poly_in.opa = lo ? t2 : v;
				poly_in.opb = lo ? t2 : v;
				poly_in.opc = lo ? t : v;
			end
			default: begin
				poly_in.opa = t;
				poly_in.opb = ONE_FX;
				poly_in.opc = ONE_FX;
			end
		endcase

		// 10t for the elastic curve
		el_in.x       = {t, 3'b000} + {2'b00, t, 1'b0};
		el_in.at_zero = t == '0;
		el_in.at_one  = t == ONE_FX;
	end

	// Input register
	always_ff @(posedge clk) begin
		if (en[0]) begin
			poly_s1  <= poly_in;
			el_s1    <= el_in;
			is_el_s1 <= curve == CRV_ELASTIC;
		end
	end

	ecu_poly u_poly (
		.clk    (clk),
		.en     (en),
		.in_s1  (poly_s1),
		.res_s5 (poly_res_s5)
	);

	ecu_elastic u_elastic (
		.clk   (clk),
		.en    (en),
		.in_s1 (el_s1),
		.res   (el_res)
	);

	// Carry the path select alongside the datapath stages
	always_ff @(posedge clk) begin
		if (en[1]) begin
			is_el_s2 <= is_el_s1;
		end
		if (en[2]) begin
			is_el_s3 <= is_el_s2;
		end
		if (en[3]) begin
			is_el_s4 <= is_el_s3;
		end
		if (en[4]) begin
			is_el_s5 <= is_el_s4;
		end
	end

	// Output register: hold while the result side stalls
	always_ff @(posedge clk) begin
		if (en[5]) begin
			res_s6 <= is_el_s5 ? el_res : poly_res_s5;
		end
	end

	assign m_tdata = {{(OUT_DATA_W - OUT_W){1'b0}}, res_s6};

endmodule

// ===== dv/easing_curve_unit_tb.sv =====
`timescale 1ns / 100ps

module easing_curve_unit_tb;

	// Fixed-point constants of the curve arithmetic
	localparam int              FRAC      = 16;
	localparam longint unsigned ONE       = 64'd1 << FRAC;
	localparam longint unsigned HALF      = 64'd1 << (FRAC - 1);
	localparam longint unsigned UNIT_Q30  = 64'd1 << 30;
	localparam longint unsigned PI_Q30    = 64'd3373259426;
	localparam longint unsigned LN2_Q30   = 64'd744261118;
	localparam longint unsigned OVERSHOOT = 64'd1827057613;   // 1.70158 in Q30
	localparam int              LUT_LEN   = 256;

	// Codes outside the defined curve set fall back to linear
	localparam logic [3:0] MODE_UNDEF_LO = 4'd12;
	localparam logic [3:0] MODE_UNDEF_HI = 4'd15;

	localparam int STALL_LIMIT = 4000;
	localparam int DIR_ROWS    = 26;
	localparam int PHASE1_REQS = 300;
	localparam int PHASE2_REQS = 300;
	localparam int PHASE3_REQS = 250;

	typedef struct packed {
		logic [3:0]  mode;
		logic [16:0] progress;
		logic        typed;
		logic [17:0] value;
	} dir_row_t;

	typedef struct packed {
		logic [3:0]  mode;
		logic [16:0] progress;
		logic [17:0] value;
	} eased_rec_t;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [ecu_pkg::IN_DATA_W-1:0]  s_tdata;   // [16:0] progress
	logic [ecu_pkg::MODE_W-1:0]     s_tuser;   // [3:0] mode
	logic                           m_tvalid;
	logic                           m_tready;
	logic [ecu_pkg::OUT_DATA_W-1:0] m_tdata;   // [17:0] eased_value

	longint unsigned sine_mag [LUT_LEN];
	logic            sine_neg [LUT_LEN];
	longint unsigned pow2_lut [LUT_LEN];

	eased_rec_t pending_eased [$];
	eased_rec_t head_rec;
	int         snd_idle_pct;
	int         rcv_idle_pct;
	int         requests_sent;
	int         results_checked;
	int         mismatches;
	int         stall_cycles;

	// Directed rows: extremes, saturation, both halves of the in-out curves,
	// elastic end points and the undefined codes. A typed row carries its
	// expected value; the others go through the predictor.
	dir_row_t directed_rows [DIR_ROWS] = '{
		'{ecu_pkg::MODE_LINEAR,   17'd0,      1'b1, 18'd0},
		'{ecu_pkg::MODE_LINEAR,   17'd65536,  1'b1, 18'd65536},
		'{ecu_pkg::MODE_LINEAR,   17'd131071, 1'b1, 18'd65536},
		'{ecu_pkg::MODE_QIN,      17'd0,      1'b1, 18'd0},
		'{ecu_pkg::MODE_QIN,      17'd32768,  1'b0, 18'd0},
		'{ecu_pkg::MODE_QOUT,     17'd100000, 1'b1, 18'd65536},
		'{ecu_pkg::MODE_QIO,      17'd32767,  1'b0, 18'd0},
		'{ecu_pkg::MODE_QIO,      17'd32768,  1'b0, 18'd0},
		'{ecu_pkg::MODE_QIN_ALT,  17'd65537,  1'b1, 18'd65536},
		'{ecu_pkg::MODE_QOUT_ALT, 17'd1,      1'b0, 18'd0},
		'{ecu_pkg::MODE_QIO_ALT,  17'd65535,  1'b0, 18'd0},
		'{ecu_pkg::MODE_CIN,      17'd65535,  1'b0, 18'd0},
		'{ecu_pkg::MODE_COUT,     17'd1,      1'b0, 18'd0},
		'{ecu_pkg::MODE_CIO,      17'd32767,  1'b0, 18'd0},
		'{ecu_pkg::MODE_CIO,      17'd32768,  1'b0, 18'd0},
		'{ecu_pkg::MODE_BACK,     17'd0,      1'b1, 18'd0},
		'{ecu_pkg::MODE_BACK,     17'd65536,  1'b1, 18'd65536},
		'{ecu_pkg::MODE_BACK,     17'd39322,  1'b0, 18'd0},
		'{ecu_pkg::MODE_ELASTIC,  17'd0,      1'b1, 18'd0},
		'{ecu_pkg::MODE_ELASTIC,  17'd65536,  1'b1, 18'd65536},
		'{ecu_pkg::MODE_ELASTIC,  17'd98304,  1'b1, 18'd65536},
		'{ecu_pkg::MODE_ELASTIC,  17'd1,      1'b0, 18'd0},
		'{ecu_pkg::MODE_ELASTIC,  17'd6554,   1'b0, 18'd0},
		'{ecu_pkg::MODE_ELASTIC,  17'd65535,  1'b0, 18'd0},
		'{MODE_UNDEF_LO,          17'd1234,   1'b1, 18'd1234},
		'{MODE_UNDEF_HI,          17'd131071, 1'b1, 18'd65536}
	};

	easing_curve_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Q16 product, rounded to nearest
	function automatic longint unsigned mul_q16(input longint unsigned a, input longint unsigned b);
		return (a * b + HALF) >> FRAC;
	endfunction

	// Sine over the first quarter turn by Taylor series; r in Q30 quarter turns
	function automatic longint unsigned quarter_sine(input longint unsigned r);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned pos;
		longint unsigned neg;
		x = (r * PI_Q30) >> 31;
		x2 = (x * x) >> 30;
		term = x;
		pos = x;
		neg = 0;
		for (int n = 1; n <= 7; n++) begin
			term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
			if (n % 2 == 1) begin
				neg = neg + term;
			end else begin
				pos = pos + term;
			end
		end
		if (neg >= pos) begin
			return 0;
		end
		pos = pos - neg;
		return (pos > UNIT_Q30) ? UNIT_Q30 : pos;
	endfunction

	// One period of sine (sign and magnitude) and one octave of 2^-f, both Q30
	task automatic build_luts();
		longint unsigned a;
		longint unsigned q;
		longint unsigned r;
		longint unsigned y;
		longint unsigned term;
		longint unsigned sum;
		for (int k = 0; k < LUT_LEN; k++) begin
			a = (longint'(k) << 32) / LUT_LEN;
			q = (a >> 30) & 3;
			r = a & (UNIT_Q30 - 1);
			sine_mag[k] = q[0] ? quarter_sine(UNIT_Q30 - r) : quarter_sine(r);
			sine_neg[k] = (q >= 2);
			y = (LN2_Q30 * longint'(k)) / LUT_LEN;
			term = UNIT_Q30;
			sum = UNIT_Q30;
			for (int n = 1; n <= 12; n++) begin
				term = ((term * y) >> 30) / longint'(n);
				sum = sum + term;
			end
			pow2_lut[k] = ((64'd1 << 60) + sum / 2) / sum;
		end
	endtask

	// Elastic-out: 1 + 2^(-10t) * sin(2*pi*(10t/3 - 1/4)), exact at the end points
	function automatic longint unsigned elastic_ease(input longint unsigned t);
		longint unsigned x;
		longint unsigned ph;
		longint unsigned si;
		longint unsigned ip;
		longint unsigned fr;
		longint unsigned ei;
		longint unsigned e;
		longint unsigned scaled;
		if (t == 0) begin
			return 0;
		end
		if (t >= ONE) begin
			return ONE;
		end
		x = 10 * t;
		ph = (((x << (32 - FRAC)) + 9 * UNIT_Q30) / 3) & 64'hFFFF_FFFF;
		si = (ph * LUT_LEN + (64'd1 << 31)) >> 32;
		if (si >= LUT_LEN) begin
			si = si - LUT_LEN;
		end
		ip = x >> FRAC;
		fr = x & (ONE - 1);
		ei = (fr * LUT_LEN + HALF) >> FRAC;
		// rounding up to a full octave wraps to entry zero one octave down
		if (ei >= LUT_LEN) begin
			ei = 0;
			ip = ip + 1;
		end
		e = (ip < 63) ? (pow2_lut[int'(ei)] >> ip) : 0;
		scaled = (e * sine_mag[int'(si)] + (64'd1 << (59 - FRAC))) >> (60 - FRAC);
		return sine_neg[int'(si)] ? ONE - scaled : ONE + scaled;
	endfunction

	// Eased value for one request; arithmetic wraps mod 2^64, keep the low 18 bits
	function automatic logic [17:0] ease_predict(input logic [3:0] mode, input logic [16:0] progress);
		longint unsigned t;
		longint unsigned u;
		longint unsigned v;
		longint unsigned c1;
		longint unsigned r;
		t = (progress > ONE) ? ONE : longint'(progress);
		u = ONE - t;
		case (mode)
			ecu_pkg::MODE_QIN, ecu_pkg::MODE_QIN_ALT: begin
				r = mul_q16(t, t);
			end
			ecu_pkg::MODE_QOUT, ecu_pkg::MODE_QOUT_ALT: begin
				r = ONE - mul_q16(u, u);
			end
			ecu_pkg::MODE_QIO, ecu_pkg::MODE_QIO_ALT: begin
				if (t < HALF) begin
					r = mul_q16(2 * t, t);
				end else begin
					v = 2 * u;
					r = ONE - ((v * v + ONE) >> (FRAC + 1));
				end
			end
			ecu_pkg::MODE_CIN: begin
				r = mul_q16(mul_q16(t, t), t);
			end
			ecu_pkg::MODE_COUT: begin
				r = ONE - mul_q16(mul_q16(u, u), u);
			end
			ecu_pkg::MODE_CIO: begin
				if (t < HALF) begin
					r = mul_q16(mul_q16(2 * t, 2 * t), t);
				end else begin
					v = 2 * u;
					r = ONE - ((mul_q16(mul_q16(v, v), v) + 1) >> 1);
				end
			end
			ecu_pkg::MODE_BACK: begin
				c1 = (OVERSHOOT + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
				r = ONE - mul_q16(c1 + ONE, mul_q16(mul_q16(u, u), u))
					+ mul_q16(c1, mul_q16(u, u));
			end
			ecu_pkg::MODE_ELASTIC: begin
				r = elastic_ease(t);
			end
			default: begin
				r = t;
			end
		endcase
		return r[17:0];
	endfunction

	// Present one request, hold it until taken, then log its expected value
	task automatic drive_request(input logic [3:0] mode, input logic [16:0] progress,
			input logic [17:0] value);
		eased_rec_t rec;
		while ($urandom_range(99) < snd_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= ecu_pkg::IN_DATA_W'(progress);
		do begin
			@(posedge clk);
		end while (!s_tready);
		@(negedge clk);
		rec.mode = mode;
		rec.progress = progress;
		rec.value = value;
		pending_eased.push_back(rec);
		requests_sent++;
	endtask

	// Hold off new requests until every outstanding result is back
	task automatic hold_until_drained();
		s_tvalid <= 1'b0;
		while (pending_eased.size() != 0) begin
			@(negedge clk);
		end
	endtask

	function automatic logic [16:0] pick_progress();
		int sel;
		sel = $urandom_range(99);
		if (sel < 70) begin
			return 17'($urandom_range(0, 65536));
		end else if (sel < 82) begin
			return 17'($urandom_range(65537, 131071));
		end else if (sel < 92) begin
			// around the in-out split and the ends
			case ($urandom_range(5))
				0: return 17'd0;
				1: return 17'd1;
				2: return 17'd32767;
				3: return 17'd32768;
				4: return 17'd65535;
				default: return 17'd65536;
			endcase
		end else begin
			return 17'($urandom_range(0, 1023));
		end
	endfunction

	task automatic run_random(input int count);
		logic [3:0]  mode;
		logic [16:0] progress;
		for (int i = 0; i < count; i++) begin
			mode = ($urandom_range(99) < 88) ? 4'($urandom_range(0, 11)) : 4'($urandom_range(12, 15));
			progress = pick_progress();
			drive_request(mode, progress, ease_predict(mode, progress));
		end
	endtask

	// Receiver: drop tready at random per the current idle share
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= rcv_idle_pct);
	end

	// Compare every accepted result against the oldest outstanding request
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_eased.size() == 0) begin
				$display("%0t ns: result %0d with no request outstanding", $time,
					$signed(m_tdata[ecu_pkg::OUT_W-1:0]));
				mismatches++;
			end else begin
				head_rec = pending_eased.pop_front();
				results_checked++;
				if (m_tdata[ecu_pkg::OUT_W-1:0] !== head_rec.value) begin
					$display("%0t ns: mode %0d progress %0d expected %0d actual %0d", $time,
						head_rec.mode, head_rec.progress, $signed(head_rec.value),
						$signed(m_tdata[ecu_pkg::OUT_W-1:0]));
					mismatches++;
				end
			end
		end
	end

	// Watchdog: end the run if nothing moves on either side for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
			end
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t ns: no request or result moved for %0d cycles", $time, STALL_LIMIT);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		snd_idle_pct = 13;
		rcv_idle_pct = 63;
		requests_sent = 0;
		results_checked = 0;
		mismatches = 0;
		stall_cycles = 0;
		build_luts();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIR_ROWS; i++) begin
			drive_request(directed_rows[i].mode, directed_rows[i].progress,
				directed_rows[i].typed ? directed_rows[i].value :
				ease_predict(directed_rows[i].mode, directed_rows[i].progress));
		end
		hold_until_drained();

		// sender mostly busy, receiver stalls often
		run_random(PHASE1_REQS);
		hold_until_drained();

		// sender gappy, receiver mostly ready
		snd_idle_pct = 63;
		rcv_idle_pct = 13;
		run_random(PHASE2_REQS);

		// back to back on both sides
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		run_random(PHASE3_REQS);

		hold_until_drained();
		repeat (2 * ecu_pkg::NSTG + 4) @(negedge clk);

		$display("Sent %0d requests (%0d directed, rest random over all 16 curve codes).",
			requests_sent, DIR_ROWS);
		$display("Checked %0d eased values under three stall mixes, %0d mismatches.",
			results_checked, mismatches);
		if (mismatches == 0 && pending_eased.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
